// ===== src/dbfm_pkg.sv =====
// Shared widths and control types for the decimate-by-four magnitude block.
// Used by dbfm_sqacc, dbfm_isqrt and decimate_by_four_magnitude_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dbfm_pkg;

  localparam int unsigned PressInW  = 24;
  localparam int unsigned PressSumW = 26;
  localparam int unsigned AccelW    = 16;
  localparam int unsigned AxisW     = 18;
  localparam int unsigned SumSqW    = 2 * AxisW;
  localparam int unsigned MagW      = AxisW;
  localparam int unsigned NumAxes   = 3;
  localparam int unsigned RootSteps = SumSqW / 2;
  localparam int unsigned RemW      = MagW + 2;
  localparam int unsigned MagMax    = 227023;

  // Commands from the sequencer to the square-and-accumulate unit.
  typedef struct packed {
    logic clear;
    logic mac;
  } sq_ctrl_t;

endpackage
`default_nettype wire

// ===== src/decimate_by_four_magnitude_top.sv =====
// Top level of the boxcar decimator with vector magnitude.
// Depends on dbfm_pkg, dbfm_sqacc and dbfm_isqrt.
`timescale 1ns / 1ps
`default_nettype none
// Each input beat carries one sensor sample: a 24 bit unsigned pressure reading
// and three signed 16 bit acceleration axes. Samples are summed per channel in
// groups of GROUP_SIZE. The beat that completes a group yields one output beat
// holding the 26 bit pressure group sum (average times GROUP_SIZE) and the
// floor square root of the sum of the squared axis group sums (magnitude of the
// averaged acceleration times GROUP_SIZE). Sums wrap at their widths if a large
// GROUP_SIZE overflows them. A beat that does not complete a group is taken
// at once. The closing beat holds in_stall_o high while the block squares the
// three axis sums on the shared multiplier, adds the last product, starts the
// root unit, waits for its eighteen root steps (one result bit per cycle from
// a 36 bit radicand) and loads the output register, so no new sample is
// taken until that result is loaded. Beats that do not close a group are
// still taken while a finished result waits in the output register.
module decimate_by_four_magnitude_top #(
  parameter int unsigned GROUP_SIZE = 4
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [dbfm_pkg::PressInW-1:0]         pressure_sample_i,
  input  logic signed [dbfm_pkg::AccelW-1:0]    accel_x_i,
  input  logic signed [dbfm_pkg::AccelW-1:0]    accel_y_i,
  input  logic signed [dbfm_pkg::AccelW-1:0]    accel_z_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [dbfm_pkg::PressSumW-1:0]        pressure_sum_o,
  output logic [dbfm_pkg::MagW-1:0]             accel_magnitude_o
);
  import dbfm_pkg::*;

  localparam int unsigned PhaseW = $clog2(GROUP_SIZE);

  typedef enum logic [2:0] {
    S_ACC,
    S_SQ,
    S_DRAIN,
    S_START,
    S_WAIT,
    S_OUT
  } state_e;

  state_e                state_q;
  logic [PhaseW-1:0]     phase_q;
  logic [PressSumW-1:0]  press_acc_q;
  logic [AxisW-1:0]      axis_acc_q [NumAxes];
  logic [AxisW-1:0]      mag_q      [NumAxes];
  logic [1:0]            axis_sel_q;
  logic [PressSumW-1:0]  press_hold_q;
  logic                  out_valid_q;
  logic [PressSumW-1:0]  press_out_q;
  logic [MagW-1:0]       mag_out_q;

  logic                  in_beat;
  logic                  last_beat;
  logic                  out_load;
  logic [PressSumW-1:0]  press_next;
  logic [AxisW-1:0]      axis_next  [NumAxes];
  logic [AccelW-1:0]     accel_in   [NumAxes];
  sq_ctrl_t              sq_ctrl;
  logic [SumSqW-1:0]     sum_sq;
  logic                  root_start;
  logic [MagW-1:0]       root;
  logic                  root_done;

  assign in_stall_o = (state_q != S_ACC);
  assign in_beat    = in_valid_i && !in_stall_o;
  assign last_beat  = (phase_q == PhaseW'(GROUP_SIZE - 1));

  // The finished result moves into the output register once that register is
  // empty or its current beat is taken in the same cycle.
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  assign accel_in[0] = accel_x_i;
  assign accel_in[1] = accel_y_i;
  assign accel_in[2] = accel_z_i;

  // Running sums including the current beat; they wrap at their widths.
  always_comb begin
    press_next = press_acc_q + PressSumW'(pressure_sample_i);
    for (int k = 0; k < NumAxes; k++) begin
      axis_next[k] = axis_acc_q[k] + {{(AxisW - AccelW){accel_in[k][AccelW-1]}}, accel_in[k]};
    end
  end

  assign sq_ctrl.clear = in_beat && last_beat;
  assign sq_ctrl.mac   = (state_q == S_SQ);
  assign root_start    = (state_q == S_START);

  dbfm_sqacc u_sqacc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (sq_ctrl),
    .operand_i (mag_q[axis_sel_q]),
    .sum_o     (sum_sq)
  );

  dbfm_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start),
    .radicand_i (sum_sq),
    .root_o     (root),
    .done_o     (root_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_ACC;
      phase_q      <= '0;
      press_acc_q  <= '0;
      axis_sel_q   <= '0;
      press_hold_q <= '0;
      out_valid_q  <= 1'b0;
      press_out_q  <= '0;
      mag_out_q    <= '0;
      for (int k = 0; k < NumAxes; k++) begin
        axis_acc_q[k] <= '0;
        mag_q[k]      <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_ACC: begin
          if (in_beat) begin
            if (last_beat) begin
              // Close the group: keep the sums and the axis magnitudes, clear
              // the running sums for the next group.
              phase_q      <= '0;
              press_acc_q  <= '0;
              press_hold_q <= press_next;
              axis_sel_q   <= '0;
              for (int k = 0; k < NumAxes; k++) begin
                axis_acc_q[k] <= '0;
                mag_q[k]      <= axis_next[k][AxisW-1] ? (~axis_next[k] + AxisW'(1))
                                                        : axis_next[k];
              end
              state_q <= S_SQ;
            end else begin
              phase_q     <= phase_q + PhaseW'(1);
              press_acc_q <= press_next;
              for (int k = 0; k < NumAxes; k++) begin
                axis_acc_q[k] <= axis_next[k];
              end
            end
          end
        end
        S_SQ: begin
          if (axis_sel_q == 2'(NumAxes - 1)) begin
            state_q <= S_DRAIN;
          end else begin
            axis_sel_q <= axis_sel_q + 2'd1;
          end
        end
        S_DRAIN: begin
          state_q <= S_START;
        end
        S_START: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (root_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            press_out_q <= press_hold_q;
            mag_out_q   <= root;
            state_q     <= S_ACC;
          end
        end
        default: begin
          state_q <= S_ACC;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign pressure_sum_o    = press_out_q;
  assign accel_magnitude_o = mag_out_q;

`ifndef NO_ASSERTIONS
  // The root unit only reports completion while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_done |-> (state_q == S_WAIT))
    else $error("root unit finished outside the wait state");

  // A beat that closes a group always starts the squaring pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && last_beat) |=> (state_q == S_SQ && axis_sel_q == 2'd0))
    else $error("closing beat did not start the squaring pass");

  // A new result appears only from the output-load step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result loaded outside the output step");

  // The magnitude of three 18 bit sums never exceeds its bound.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (accel_magnitude_o <= MagW'(MagMax)))
    else $error("magnitude out of range");
`endif

endmodule
`default_nettype wire

// ===== src/dbfm_sqacc.sv =====
// Square-and-accumulate unit: one 18x18 multiplier with a registered product
// and a 36 bit accumulator. Depends on dbfm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dbfm_sqacc (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dbfm_pkg::sq_ctrl_t                ctrl_i,
  input  logic [dbfm_pkg::AxisW-1:0]        operand_i,
  output logic [dbfm_pkg::SumSqW-1:0]       sum_o
);
  import dbfm_pkg::*;

  logic [SumSqW-1:0] prod_q;
  logic              prod_vld_q;
  logic [SumSqW-1:0] sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q     <= '0;
      prod_vld_q <= 1'b0;
      sum_q      <= '0;
    end else begin
      prod_q     <= SumSqW'(operand_i) * SumSqW'(operand_i);
      prod_vld_q <= ctrl_i.mac;
      if (ctrl_i.clear) begin
        sum_q <= '0;
      end else if (prod_vld_q) begin
        sum_q <= sum_q + prod_q;
      end
    end
  end

  assign sum_o = sum_q;

endmodule
`default_nettype wire

// ===== src/dbfm_isqrt.sv =====
// Iterative floor square root, one result bit per cycle (digit recurrence).
// Depends on dbfm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dbfm_isqrt (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [dbfm_pkg::SumSqW-1:0]       radicand_i,
  output logic [dbfm_pkg::MagW-1:0]         root_o,
  output logic                              done_o
);
  import dbfm_pkg::*;

  localparam int unsigned CntW = $clog2(RootSteps);

  logic [SumSqW-1:0] rad_q;
  logic [RemW-1:0]   rem_q;
  logic [MagW-1:0]   root_q;
  logic [CntW-1:0]   cnt_q;
  logic              busy_q;
  logic              done_q;

  logic [RemW-1:0]   rem_shift;
  logic [RemW-1:0]   trial;
  logic              fits;

  // Before every step the remainder stays below 2^18, so its top bits are zero.
  assign rem_shift = {rem_q[RemW-3:0], rad_q[SumSqW-1 -: 2]};
  assign trial     = {root_q, 2'b01};
  assign fits      = (rem_shift >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rad_q  <= radicand_i;
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rad_q  <= {rad_q[SumSqW-3:0], 2'b00};
        rem_q  <= fits ? (rem_shift - trial) : rem_shift;
        root_q <= {root_q[MagW-2:0], fits};
        cnt_q  <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(RootSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

// ===== test/tb_decimate_by_four_magnitude_top.sv =====
// Self-checking testbench for decimate_by_four_magnitude_top: a directed table
// and then bursts of random samples, checked against a predictor of its own.
// Depends on dbfm_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps
module tb_decimate_by_four_magnitude_top;
  import dbfm_pkg::*;

  // The block runs with its default group size. Four samples per group keep
  // every sum inside its width, so no sum ever wraps in this run.
  localparam int unsigned GroupSize     = 4;
  localparam int unsigned DirectedRows  = 24;
  localparam int unsigned RandomItems   = 1126;
  localparam int unsigned DrainEvery    = 400;  // sender waits for all results
  localparam int unsigned HoldOffAt     = 200;  // input beats before the long hold-off
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned TailCycles    = 60;   // room for a stray result after the last group
  localparam int unsigned IdleLimit     = 2000; // cycles with no beat on either side

  typedef struct packed {
    logic [PressInW-1:0] pressure;
    logic [AccelW-1:0]   ax;
    logic [AccelW-1:0]   ay;
    logic [AccelW-1:0]   az;
  } sample_t;

  typedef struct packed {
    logic [PressSumW-1:0] pressure_sum;
    logic [MagW-1:0]      magnitude;
  } group_result_t;

  // A directed row may pin the result of the group it closes. Rows without a
  // pinned result are checked against the predictor like the random part.
  typedef struct packed {
    sample_t       sample;
    logic          pinned;
    group_result_t want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [PressInW-1:0] pressure_sample = '0;
  logic [AccelW-1:0] accel_x = '0;
  logic [AccelW-1:0] accel_y = '0;
  logic [AccelW-1:0] accel_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PressSumW-1:0] pressure_sum;
  logic [MagW-1:0] accel_magnitude;

  // The pinned flag and value travel with the payload so that the monitor
  // knows which expectation belongs to the beat it sees accepted.
  logic cur_pinned = 1'b0;
  group_result_t cur_want = '0;

  // Handshake flags, sampled at the falling edge and used at the next rising
  // edge, where the beat is actually taken.
  bit in_take = 1'b0;
  bit out_take = 1'b0;
  int unsigned beats_in = 0;
  int unsigned mismatches = 0;

  // Predictor state: running sums of the current group and its sample count.
  logic [PressSumW-1:0] press_run = '0;
  logic [AxisW-1:0]     axis_run [NumAxes] = '{default: '0};
  int unsigned          group_fill = 0;
  group_result_t        expected_groups [$];
  group_result_t        predicted;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  decimate_by_four_magnitude_top #(
    .GROUP_SIZE(GroupSize)
  ) dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .pressure_sample_i(pressure_sample),
    .accel_x_i        (accel_x),
    .accel_y_i        (accel_y),
    .accel_z_i        (accel_z),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .pressure_sum_o   (pressure_sum),
    .accel_magnitude_o(accel_magnitude)
  );

  // Square of an 18 bit two's complement axis sum. The most negative sum has a
  // magnitude of 2^17, which still fits an unsigned 18 bit value.
  function automatic logic [SumSqW-1:0] axis_square(input logic [AxisW-1:0] s);
    logic [AxisW-1:0] m;
    m = s[AxisW-1] ? (~s + 1'b1) : s;
    return SumSqW'(m) * SumSqW'(m);
  endfunction

  // Floor square root, built one result bit at a time from the top.
  function automatic logic [MagW-1:0] floor_root(input logic [SumSqW-1:0] v);
    logic [MagW-1:0] root;
    logic [MagW-1:0] trial;
    root = '0;
    for (int b = MagW - 1; b >= 0; b--) begin
      trial = root | (MagW'(1) << b);
      if (SumSqW'(trial) * SumSqW'(trial) <= v) root = trial;
    end
    return root;
  endfunction

  // Adds one sample to the running sums. Returns 1 with the group result when
  // the sample closes a group, which also clears the sums.
  function automatic bit accumulate_sample(input sample_t s, output group_result_t r);
    logic [AccelW-1:0] axis [NumAxes];
    logic [SumSqW-1:0] sum_sq;
    axis = '{s.ax, s.ay, s.az};
    r = '0;
    press_run = press_run + PressSumW'(s.pressure);
    for (int k = 0; k < NumAxes; k++)
      axis_run[k] = axis_run[k] + {{(AxisW - AccelW){axis[k][AccelW-1]}}, axis[k]};
    group_fill++;
    if (group_fill < GroupSize) return 1'b0;
    sum_sq = axis_square(axis_run[0]) + axis_square(axis_run[1]) + axis_square(axis_run[2]);
    r.pressure_sum = press_run;
    r.magnitude = floor_root(sum_sq);
    press_run = '0;
    axis_run = '{default: '0};
    group_fill = 0;
    return 1'b1;
  endfunction

  // Half the random values are plain random, the rest lean on the extremes
  // and on values near zero, where signs flip.
  function automatic logic [PressInW-1:0] rand_pressure();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      2:       return PressInW'($urandom_range(0, 255));
      3:       return {1'b1, (PressInW - 1)'($urandom())};
      default: return PressInW'($urandom());
    endcase
  endfunction

  function automatic logic [AccelW-1:0] rand_axis();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return AccelW'($urandom_range(0, 64)) - 16'd32;
      3:       return ($urandom_range(0, 1) != 0) ? 16'h7FFF - AccelW'($urandom_range(0, 255))
                                                  : 16'h8000 + AccelW'($urandom_range(0, 255));
      default: return AccelW'($urandom());
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.pressure = rand_pressure();
    s.ax = rand_axis();
    s.ay = rand_axis();
    s.az = rand_axis();
    return s;
  endfunction

  // Monitor. Everything the block drives settles long before the falling
  // edge, and the testbench only changes inputs at the rising edge, so what is
  // seen here is exactly what the next rising edge will take.
  always @(negedge clk) begin
    in_take  = rst_n && in_valid && !in_stall;
    out_take = rst_n && out_valid && !out_stall;
    if (in_take) begin
      beats_in++;
      if (accumulate_sample({pressure_sample, accel_x, accel_y, accel_z}, predicted)) begin
        expected_groups.push_back(cur_pinned ? cur_want : predicted);
      end
    end
    if (out_take) begin
      if (expected_groups.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual sum %0d magnitude %0d",
                 $time, pressure_sum, accel_magnitude);
        mismatches++;
      end else begin
        predicted = expected_groups.pop_front();
        if (pressure_sum !== predicted.pressure_sum) begin
          $display("%0t: pressure_sum mismatch: expected %0d, actual %0d",
                   $time, predicted.pressure_sum, pressure_sum);
          mismatches++;
        end
        if (accel_magnitude !== predicted.magnitude) begin
          $display("%0t: accel_magnitude mismatch: expected %0d, actual %0d",
                   $time, predicted.magnitude, accel_magnitude);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: a run that goes this long without a beat on either side is hung.
  always @(posedge clk) begin : watchdog
    int unsigned idle_cycles;
    if (!rst_n || in_take || out_take) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Receiver. It changes its stall pattern after each stretch of random length: no stall,
  // light or heavy random stall, or stall on every other cycle. Once, after
  // some input beats, it holds off for a long stretch so that a finished
  // result sits in the output register and the block stalls its input.
  initial begin : receiver
    int unsigned mode;
    int unsigned stretch;
    bit held_off;
    held_off = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!held_off && beats_in >= HoldOffAt) begin
        out_stall <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk);
        held_off = 1'b1;
      end
      mode = $urandom_range(0, 3);
      stretch = $urandom_range(10, 80);
      repeat (stretch) begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
        @(posedge clk);
      end
    end
  end

  // Called at a rising edge: puts a beat on the input and returns at the
  // rising edge that takes it, so the next beat can follow without a gap.
  task automatic offer_sample(input sample_t s, input logic pin, input group_result_t want);
    in_valid <= 1'b1;
    pressure_sample <= s.pressure;
    accel_x <= s.ax;
    accel_y <= s.ay;
    accel_z <= s.az;
    cur_pinned <= pin;
    cur_want <= want;
    @(posedge clk);
    while (!in_take) @(posedge clk);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Directed table, one group of four samples per block of rows. The closing
  // row of a group pins its result where it can be read off directly.
  directed_row_t directed_rows [DirectedRows] = '{
    // Right after reset: all zeros give zero sums.
    '{'{24'h000000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '{26'd0, 18'd0}},
    '{'{24'h000000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '{26'd0, 18'd0}},
    '{'{24'h000000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '{26'd0, 18'd0}},
    '{'{24'h000000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, '{26'd0, 18'd0}},
    // Largest pressure and most negative axes: both outputs at their maxima.
    '{'{24'hFFFFFF, 16'h8000, 16'h8000, 16'h8000}, 1'b0, '{26'd0, 18'd0}},
    '{'{24'hFFFFFF, 16'h8000, 16'h8000, 16'h8000}, 1'b0, '{26'd0, 18'd0}},
    '{'{24'hFFFFFF, 16'h8000, 16'h8000, 16'h8000}, 1'b0, '{26'd0, 18'd0}},
    '{'{24'hFFFFFF, 16'h8000, 16'h8000, 16'h8000}, 1'b1,
      '{26'd67108860, MagW'(MagMax)}},
    // Largest positive axes with zero pressure.
    '{'{24'h000000, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b0, '{26'd0, 18'd0}},
    '{'{24'h000000, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b0, '{26'd0, 18'd0}},
    '{'{24'h000000, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b0, '{26'd0, 18'd0}},
    '{'{24'h000000, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b0, '{26'd0, 18'd0}},
    // A 3-4-5 triangle with a negative leg: sums of -12 and 16 give 20.
    '{'{24'd100, 16'hFFFD, 16'h0004, 16'h0000}, 1'b0, '{26'd0, 18'd0}},
    '{'{24'd100, 16'hFFFD, 16'h0004, 16'h0000}, 1'b0, '{26'd0, 18'd0}},
    '{'{24'd100, 16'hFFFD, 16'h0004, 16'h0000}, 1'b0, '{26'd0, 18'd0}},
    '{'{24'd100, 16'hFFFD, 16'h0004, 16'h0000}, 1'b1, '{26'd400, 18'd20}},
    // A single negative axis: the magnitude is the size of its sum.
    '{'{24'd1, 16'h0000, 16'h0000, 16'hFC18}, 1'b0, '{26'd0, 18'd0}},
    '{'{24'd2, 16'h0000, 16'h0000, 16'hFC18}, 1'b0, '{26'd0, 18'd0}},
    '{'{24'd3, 16'h0000, 16'h0000, 16'hFC18}, 1'b0, '{26'd0, 18'd0}},
    '{'{24'd4, 16'h0000, 16'h0000, 16'hFC18}, 1'b1, '{26'd10, 18'd4000}},
    // Alternating bit patterns, and extremes of opposite sign that cancel.
    '{'{24'hAAAAAA, 16'h7FFF, 16'hAAAA, 16'h5555}, 1'b0, '{26'd0, 18'd0}},
    '{'{24'h555555, 16'h8000, 16'h5555, 16'hAAAA}, 1'b0, '{26'd0, 18'd0}},
    '{'{24'hAAAAAA, 16'h7FFF, 16'hAAAA, 16'h5555}, 1'b0, '{26'd0, 18'd0}},
    '{'{24'h555555, 16'h8000, 16'h5555, 16'hAAAA}, 1'b0, '{26'd0, 18'd0}}
  };

  initial begin : stimulus
    int unsigned sent;
    int unsigned burst;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows, with a short gap after some of them.
    for (int i = 0; i < DirectedRows; i++) begin
      offer_sample(directed_rows[i].sample, directed_rows[i].pinned, directed_rows[i].want);
      if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 6));
    end

    // Random samples in bursts. Every so often the sender stops and waits for
    // every expected result, which may leave a group half filled meanwhile.
    sent = 0;
    while (sent < RandomItems) begin
      burst = $urandom_range(1, 24);
      for (int j = 0; j < burst && sent < RandomItems; j++) begin
        offer_sample(random_sample(), 1'b0, '0);
        sent++;
        if (sent % DrainEvery == 0) begin
          pause_sender(1);
          while (expected_groups.size() != 0) @(posedge clk);
        end
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
    end

    // The run ends on a partly filled group, so a stray result would show up
    // in the tail cycles.
    pause_sender(1);
    while (expected_groups.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
